FILE: sv/case_insensitive_substring_search_defines.svh
// assertion helpers for the substring search block
// every macro samples on clock and is switched off while reset is high
`ifndef CASE_INSENSITIVE_SUBSTRING_SEARCH_DEFINES_SVH
`define CASE_INSENSITIVE_SUBSTRING_SEARCH_DEFINES_SVH

// same-cycle implication
`define CIS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define CIS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: sv/cis_pkg.sv
`default_nettype none

package cis_pkg;

   localparam int TEXT_W      = 8;
   localparam int START_W     = 16;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int PAT_BYTES   = 16;
   localparam int LEN_FIELD_W = 5;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 2'd2;

   localparam logic [TEXT_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [TEXT_W-1:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [TEXT_W-1:0] CASE_OFFSET  = 8'h20;

   typedef struct packed {
      logic [TEXT_W-1:0] text_byte;
      logic              end_of_text;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [START_W-1:0] match_start;
   } rsp_type;

   // ascii upper case letters map to lower case, all else unchanged
   function automatic logic [TEXT_W-1:0] fold_byte(input logic [TEXT_W-1:0] c);
      logic [TEXT_W-1:0] r;
      r = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: sv/case_insensitive_substring_search.sv
// path: an accepted byte is held in the input register, and its result, if any, in the result register
// throughput: one text byte per cycle unless stalled, set by the single compare stage over the whole window
// reset: synchronous, active high; clears the item and result valid flags, the byte count,
// the reported flag, the pattern to all zeros and the pattern length to one
`default_nettype none
`include "case_insensitive_substring_search_defines.svh"

module case_insensitive_substring_search
   import cis_pkg::*;
#(
   parameter int MAX_PATTERN = 16,
   parameter int INDEX_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // pattern length register holds 1..MAX_PATTERN
   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   // byte count reaches START_MAX + MAX_PATTERN, which fits one bit above the index
   localparam int CNT_W = INDEX_BITS + 1;
   // window of earlier bytes; one spare entry keeps the array non-empty
   localparam int WIN_D = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
   localparam int PIDX_W = $clog2(PAT_BYTES);

   localparam logic [CNT_W-1:0] COUNT_MAX =
      CNT_W'((64'd1 << INDEX_BITS) - 64'd1 + 64'(MAX_PATTERN));
   localparam logic [INDEX_BITS-1:0] START_MAX = '1;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [CSR_DATA_W-1:0] pat_low_ff;
   logic [CSR_DATA_W-1:0] pat_high_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [LEN_W-1:0]      len_in;
   logic [LEN_FIELD_W-1:0] len_raw;

   // zero acts as one, anything above the window size is clipped
   always_comb begin
      len_raw = csr_wdata[LEN_FIELD_W-1:0];
      len_in  = len_ff;
      if (len_raw == '0) begin
         len_in = LEN_W'(1);
      end else if (int'(len_raw) > MAX_PATTERN) begin
         len_in = LEN_W'(MAX_PATTERN);
      end else begin
         len_in = LEN_W'(len_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         len_ff      <= LEN_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:    pat_low_ff  <= csr_wdata;
            CSR_PATTERN_HIGH:   pat_high_ff <= csr_wdata;
            CSR_PATTERN_LENGTH: len_ff      <= len_in;
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   // ------------------------------------------------------------------
   // input register and pipeline control
   // ------------------------------------------------------------------
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    advance;
   logic    proc;

   // the result register frees up when empty or when its item is taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign proc      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // ------------------------------------------------------------------
   // text state: window, byte count, reported flag
   // ------------------------------------------------------------------
   logic [TEXT_W-1:0] recent_ff [WIN_D];
   logic [TEXT_W-1:0] recent_in [WIN_D];
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic              rep_ff;
   logic              rep_in;

   logic [TEXT_W-1:0] win     [MAX_PATTERN];
   logic [TEXT_W-1:0] pat     [PAT_BYTES];
   logic [MAX_PATTERN-1:0] byte_ok;
   logic [CNT_W-1:0]  cnt_next;
   logic              hit;
   logic              last;
   logic              emit;
   logic [CNT_W-1:0]  start_full;
   logic [INDEX_BITS-1:0] start_sat;
   logic [PIDX_W-1:0] pidx;

   assign last = in_data_ff.end_of_text;

   // the count stops at START_MAX + MAX_PATTERN, the end of the longest pattern starting at START_MAX
   assign cnt_next = (cnt_ff < COUNT_MAX) ? cnt_ff + CNT_W'(1) : cnt_ff;

   always_comb begin
      for (int b = 0; b < PAT_BYTES / 2; b++) begin
         pat[b]                 = pat_low_ff[b*TEXT_W +: TEXT_W];
         pat[b + PAT_BYTES / 2] = pat_high_ff[b*TEXT_W +: TEXT_W];
      end
   end

   // win[k] is the byte k places before the current one
   always_comb begin
      win[0] = in_data_ff.text_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         win[k] = recent_ff[k-1];
      end
   end

   // every pattern byte compared at once against the window; places past the length always agree
   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         pidx = PIDX_W'(int'(len_ff) - 1 - k);
         if (k < int'(len_ff)) begin
            byte_ok[k] = fold_byte(win[k]) == fold_byte(pat[pidx]);
         end else begin
            byte_ok[k] = 1'b1;
         end
      end
   end

   // enough bytes of this text must have arrived to fill the pattern
   assign hit  = !rep_ff && (cnt_next >= CNT_W'(len_ff)) && (&byte_ok);
   assign emit = hit || (last && !rep_ff);

   assign start_full = cnt_next - CNT_W'(len_ff);
   assign start_sat  = start_full[INDEX_BITS] ? START_MAX : start_full[INDEX_BITS-1:0];

   // next state; end of text returns count and flag to their reset values
   always_comb begin
      recent_in[0] = in_data_ff.text_byte;
      for (int j = 1; j < WIN_D; j++) begin
         recent_in[j] = recent_ff[j-1];
      end
      if (last) begin
         cnt_in = '0;
         rep_in = 1'b0;
      end else begin
         cnt_in = cnt_next;
         rep_in = rep_ff || hit;
      end
   end

   // window bytes older than the text are never compared, so no clearing
   always_ff @(posedge clock) begin
      if (proc) begin
         recent_ff <= recent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rep_ff <= 1'b0;
      end else if (proc) begin
         cnt_ff <= cnt_in;
         rep_ff <= rep_in;
      end
   end

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= proc && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && emit) begin
         rsp_data_ff.found       <= hit;
         rsp_data_ff.match_start <= hit ? START_W'(start_sat) : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   // a not-found item never carries a start index
   `CIS_ASSERT_NOW(a_notfound_zero, rsp_valid_ff && !rsp_data_ff.found,
                   rsp_data_ff.match_start == '0)
   // the byte count never runs past its saturation point
   `CIS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_ff <= COUNT_MAX)
   // a match in the middle of a text silences the rest of it
   `CIS_ASSERT_NEXT(a_hit_sets_rep, proc && hit && !last, rep_ff)
   // the final byte of a text leaves clean state for the next one
   `CIS_ASSERT_NEXT(a_last_clears, proc && last, cnt_ff == '0 && !rep_ff)

endmodule

`default_nettype wire
